// ===== sv/lrud_pkg.sv =====
`default_nettype none
package lrud_pkg;
  localparam int unsigned DefaultEntries = 16;
  localparam logic [31:0] FloorReset = 32'd1048576;

  typedef enum logic [2:0] {
    KIND_LOOKUP   = 3'd0,
    KIND_START    = 3'd1,
    KIND_CANCEL   = 3'd2,
    KIND_PIN      = 3'd3,
    KIND_UNPIN    = 3'd4,
    KIND_DONE     = 3'd5,
    KIND_PRESSURE = 3'd6,
    KIND_NONE     = 3'd7
  } kind_t;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_NO_ENTRY = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_NO_EVICT = 3'd4;
  localparam logic [2:0] ST_NO_PRESSURE = 3'd5;

  // Search token that travels down the row of cells.
  typedef struct packed {
    logic        found;
    logic [7:0]  found_slot;
    logic        free;
    logic [7:0]  free_slot;
    logic        cand;
    logic [7:0]  cand_slot;
    logic [31:0] cand_time;
    logic [31:0] cand_key;
    logic [39:0] cand_size;
    logic        found_complete;
    logic        found_downloading;
    logic [8:0]  count;
  } scan_t;

  // Command broadcast to all cells.
  typedef struct packed {
    logic        search;
    logic        write;
    logic [7:0]  slot;
    logic        set_valid;
    logic        clr_valid;
    logic        new_entry;
    logic        touch;
    logic        clr_dl;
    logic        set_done;
    logic [31:0] key;
    logic [31:0] now;
    logic [39:0] size;
    logic        pin_valid;
    logic [31:0] pin_key;
  } cmd_t;
endpackage
`default_nettype wire

// ===== sv/lrud_cell.sv =====
`default_nettype none
module lrud_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [7:0]     my_slot,
  input  wire lrud_pkg::cmd_t cmd,
  input  wire lrud_pkg::scan_t scan_in,
  output lrud_pkg::scan_t     scan_out
);
  import lrud_pkg::*;

  logic        valid;
  logic [31:0] key;
  logic        complete;
  logic        downloading;
  logic [31:0] last_access;
  logic [39:0] size;
  logic        hit_me;
  logic        evictable;
  scan_t       scan_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.write && cmd.slot == my_slot) begin
      if (cmd.set_valid) valid <= 1'b1;
      if (cmd.clr_valid) valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write && cmd.slot == my_slot) begin
      if (cmd.new_entry) begin
        key <= cmd.key;
        complete <= 1'b0;
        downloading <= 1'b1;
        size <= '0;
      end
      if (cmd.touch || cmd.new_entry) last_access <= cmd.now;
      if (cmd.clr_dl) downloading <= 1'b0;
      if (cmd.set_done) begin
        complete <= 1'b1;
        size <= cmd.size;
      end
    end
    scan_out <= scan_next;
  end

  always_comb begin
    scan_next = scan_in;
    if (cmd.search) begin
      scan_next.count = scan_in.count + {8'd0, valid};
      if (hit_me) begin
        scan_next.found = 1'b1;
        scan_next.found_slot = my_slot;
        scan_next.found_complete = complete;
        scan_next.found_downloading = downloading;
      end
      if (!valid && !scan_in.free) begin
        scan_next.free = 1'b1;
        scan_next.free_slot = my_slot;
      end
      if (evictable && (!scan_in.cand || last_access < scan_in.cand_time)) begin
        scan_next.cand = 1'b1;
        scan_next.cand_slot = my_slot;
        scan_next.cand_time = last_access;
        scan_next.cand_key = key;
        scan_next.cand_size = size;
      end
    end
  end

  assign hit_me = valid && key == cmd.key && !scan_in.found;
  assign evictable = valid && !downloading && !(cmd.pin_valid && key == cmd.pin_key);
endmodule
`default_nettype wire

// ===== sv/lru_cache_directory_with_pinning.sv =====
`default_nettype none
// Channel  Dir  tdata fields (low to high)                      tuser
// s_axis   in   item_key, now_seconds, fill_success,            kind
//               fill_size_bytes, mem_available_kib
// m_axis   out  hit, slot_index, evicted, evicted_key,          status
//               evicted_size_bytes, entry_count
// One event passes from its transfer through S_SCAN, where the search token walks the row
// of cells, then S_DECIDE, which decides, and S_OUT, which writes the chosen cell as the
// result is made valid.
// Synchronous reset empties the directory, clears the pin and restores the floor.
// A result waits in the output register; the next event is accepted in the cycle after
// the result transfer.
module lru_cache_directory_with_pinning #(
  parameter int unsigned ENTRIES = lrud_pkg::DefaultEntries
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [143:0]  s_axis_tdata,  // key, now, success, size, mem
  input  wire logic [2:0]    s_axis_tuser,  // kind
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [87:0]        m_axis_tdata,  // hit, slot, evicted, key, size, count
  output logic [2:0]         m_axis_tuser,  // status
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_wdata
);
  import lrud_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_OUT} state_t;

  state_t      state;
  logic [8:0]  cnt;
  logic [31:0] floor_kib;
  logic        pin_valid;
  logic [31:0] pin_key;
  kind_t       kind;
  logic [31:0] ikey, inow, imem;
  logic        iok;
  logic [39:0] isize;
  cmd_t        cmd;
  cmd_t        cmd_next;
  scan_t       chain [ENTRIES+1];
  scan_t       res;
  logic [8:0]  cnt_after;
  logic [2:0]  dec_status;
  logic        dec_hit;
  logic [3:0]  dec_slot;
  logic        dec_evicted;
  logic [31:0] dec_ev_key;
  logic [39:0] dec_ev_size;

  assign chain[0] = '0;
  assign res = chain[ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lrud_cell u_cell (
      .clk(clk), .rst(rst), .my_slot(8'(g)), .cmd(cmd),
      .scan_in(chain[g]), .scan_out(chain[g+1])
    );
  end

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;

  always_comb begin
    cmd_next = cmd;
    cmd_next.write = 1'b0;
    dec_status = ST_DONE;
    dec_hit = 1'b0;
    dec_slot = res.found ? res.found_slot[3:0] : 4'd0;
    dec_evicted = 1'b0;
    dec_ev_key = '0;
    dec_ev_size = '0;
    cnt_after = res.count;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          cmd_next.search = 1'b1;
          cmd_next.key = (kind_t'(s_axis_tuser) == KIND_UNPIN) ? pin_key : s_axis_tdata[31:0];
          cmd_next.pin_valid = pin_valid;
          cmd_next.pin_key = pin_key;
        end
      end
      S_SCAN: begin
        if (cnt == 9'(ENTRIES)) cmd_next.search = 1'b0;
      end
      S_DECIDE: begin
        cmd_next.write = 1'b1;
        cmd_next.slot = res.found_slot;
        cmd_next.set_valid = 1'b0;
        cmd_next.clr_valid = 1'b0;
        cmd_next.new_entry = 1'b0;
        cmd_next.touch = 1'b0;
        cmd_next.clr_dl = 1'b0;
        cmd_next.set_done = 1'b0;
        cmd_next.now = inow;
        cmd_next.size = isize;
        case (kind)
          KIND_LOOKUP: begin
            if (!res.found) dec_status = ST_NO_ENTRY;
            else if (res.found_complete) begin
              dec_hit = 1'b1;
              cmd_next.touch = 1'b1;
            end
          end
          KIND_START: begin
            if (res.found && (res.found_complete || res.found_downloading)) begin
              dec_status = ST_PRESENT;
            end else if (res.found) begin
              cmd_next.new_entry = 1'b1;
              cmd_next.key = ikey;
            end else if (res.free) begin
              cmd_next.new_entry = 1'b1;
              cmd_next.set_valid = 1'b1;
              cmd_next.key = ikey;
              cmd_next.slot = res.free_slot;
              dec_slot = res.free_slot[3:0];
              cnt_after = res.count + 9'd1;
            end else begin
              dec_status = ST_FULL;
            end
          end
          KIND_CANCEL: begin
            if (!res.found) dec_status = ST_NO_ENTRY;
            else cmd_next.clr_dl = 1'b1;
          end
          KIND_PIN: begin
            cmd_next.touch = res.found;
          end
          KIND_UNPIN: begin
            if (!pin_valid) dec_slot = 4'd0;
            cmd_next.touch = res.found && pin_valid;
          end
          KIND_DONE: begin
            if (!res.found) dec_status = ST_NO_ENTRY;
            else begin
              cmd_next.clr_dl = 1'b1;
              cmd_next.set_done = iok;
            end
          end
          KIND_PRESSURE: begin
            dec_slot = 4'd0;
            if (imem == '0 || imem >= floor_kib) dec_status = ST_NO_PRESSURE;
            else if (!res.cand) dec_status = ST_NO_EVICT;
            else begin
              cmd_next.clr_valid = 1'b1;
              cmd_next.slot = res.cand_slot;
              dec_slot = res.cand_slot[3:0];
              dec_evicted = 1'b1;
              dec_ev_key = res.cand_key;
              dec_ev_size = res.cand_size;
              cnt_after = res.count - 9'd1;
            end
          end
          default: dec_slot = 4'd0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      floor_kib <= FloorReset;
      pin_valid <= 1'b0;
      pin_key <= '0;
      m_axis_tvalid <= 1'b0;
      cmd <= '0;
    end else begin
      if (cfg_we) floor_kib <= cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      cmd <= cmd_next;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind <= kind_t'(s_axis_tuser);
            ikey <= s_axis_tdata[31:0];
            inow <= s_axis_tdata[63:32];
            iok <= s_axis_tdata[64];
            isize <= s_axis_tdata[104:65];
            imem <= s_axis_tdata[136:105];
            cnt <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 9'd1;
          if (cnt == 9'(ENTRIES)) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          m_axis_tuser <= dec_status;
          m_axis_tdata <= {5'd0, cnt_after[4:0], dec_ev_size, dec_ev_key, dec_evicted,
                           dec_slot, dec_hit};
          if (kind == KIND_PIN) begin
            pin_valid <= 1'b1;
            pin_key <= ikey;
          end else if (kind == KIND_UNPIN) begin
            pin_valid <= 1'b0;
            pin_key <= '0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/lru_cache_directory_with_pinning_checker.sv =====
`default_nettype none
module lru_cache_directory_with_pinning_checker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  input  wire logic          s_axis_tready,
  input  wire logic [143:0]  s_axis_tdata,
  input  wire logic [2:0]    s_axis_tuser,
  input  wire logic          m_axis_tvalid,
  input  wire logic          m_axis_tready,
  input  wire logic [87:0]   m_axis_tdata,
  input  wire logic [2:0]    m_axis_tuser,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_wdata,
  output int                 fail_count,
  output int                 pending_count
);
  import lrud_pkg::*;

  localparam int Slots = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [3:0]  slot;
    logic        evicted;
    logic [31:0] ev_key;
    logic [39:0] ev_size;
    logic [4:0]  count;
  } outcome_t;

  logic        dir_valid [Slots];
  logic [31:0] dir_key [Slots];
  logic        dir_complete [Slots];
  logic        dir_loading [Slots];
  logic [31:0] dir_time [Slots];
  logic [39:0] dir_size [Slots];
  logic        pin_valid;
  logic [31:0] pin_key;
  logic [31:0] floor_kib;
  outcome_t    expected_outcomes[$];

  function automatic int lookup_slot(logic [31:0] key);
    for (int i = 0; i < Slots; i++)
      if (dir_valid[i] && dir_key[i] == key) return i;
    return -1;
  endfunction

  task automatic apply_event(input logic [2:0] kind, input logic [143:0] d);
    logic [31:0] key;
    logic [31:0] now;
    logic        ok;
    logic [39:0] fsize;
    logic [31:0] mem;
    outcome_t    r;
    int          s;
    int          n;
    key = d[31:0];
    now = d[63:32];
    ok = d[64];
    fsize = d[104:65];
    mem = d[136:105];
    r = '0;
    s = -1;
    case (kind)
      KIND_LOOKUP: begin
        s = lookup_slot(key);
        if (s < 0) r.status = ST_NO_ENTRY;
        else begin
          r.slot = s[3:0];
          if (dir_complete[s]) begin
            r.hit = 1'b1;
            dir_time[s] = now;
          end
        end
      end
      KIND_START: begin
        s = lookup_slot(key);
        if (s >= 0 && (dir_complete[s] || dir_loading[s])) begin
          r.status = ST_PRESENT;
          r.slot = s[3:0];
        end else begin
          if (s < 0)
            for (int i = Slots - 1; i >= 0; i--)
              if (!dir_valid[i]) s = i;
          if (s < 0) r.status = ST_FULL;
          else begin
            dir_valid[s] = 1'b1;
            dir_key[s] = key;
            dir_complete[s] = 1'b0;
            dir_loading[s] = 1'b1;
            dir_time[s] = now;
            dir_size[s] = '0;
            r.slot = s[3:0];
          end
        end
      end
      KIND_CANCEL: begin
        s = lookup_slot(key);
        if (s < 0) r.status = ST_NO_ENTRY;
        else begin
          dir_loading[s] = 1'b0;
          r.slot = s[3:0];
        end
      end
      KIND_PIN: begin
        pin_valid = 1'b1;
        pin_key = key;
        s = lookup_slot(key);
        if (s >= 0) begin
          dir_time[s] = now;
          r.slot = s[3:0];
        end
      end
      KIND_UNPIN: begin
        if (pin_valid) begin
          s = lookup_slot(pin_key);
          if (s >= 0) begin
            dir_time[s] = now;
            r.slot = s[3:0];
          end
        end
        pin_valid = 1'b0;
        pin_key = '0;
      end
      KIND_DONE: begin
        s = lookup_slot(key);
        if (s < 0) r.status = ST_NO_ENTRY;
        else begin
          dir_loading[s] = 1'b0;
          if (ok) begin
            dir_size[s] = fsize;
            dir_complete[s] = 1'b1;
          end
          r.slot = s[3:0];
        end
      end
      KIND_PRESSURE: begin
        if (mem == 0 || mem >= floor_kib) r.status = ST_NO_PRESSURE;
        else begin
          for (int i = 0; i < Slots; i++) begin
            if (!dir_valid[i] || dir_loading[i]) continue;
            if (pin_valid && dir_key[i] == pin_key) continue;
            if (s < 0 || dir_time[i] < dir_time[s]) s = i;
          end
          if (s < 0) r.status = ST_NO_EVICT;
          else begin
            r.evicted = 1'b1;
            r.ev_key = dir_key[s];
            r.ev_size = dir_size[s];
            r.slot = s[3:0];
            dir_valid[s] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    n = 0;
    for (int i = 0; i < Slots; i++) if (dir_valid[i]) n++;
    r.count = n[4:0];
    expected_outcomes.push_back(r);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      for (int i = 0; i < Slots; i++) begin
        dir_valid[i] = 1'b0;
        dir_key[i] = '0;
        dir_complete[i] = 1'b0;
        dir_loading[i] = 1'b0;
        dir_time[i] = '0;
        dir_size[i] = '0;
      end
      pin_valid = 1'b0;
      pin_key = '0;
      floor_kib = FloorReset;
      expected_outcomes.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (cfg_we) floor_kib = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) apply_event(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.hit = m_axis_tdata[0];
        got.slot = m_axis_tdata[4:1];
        got.evicted = m_axis_tdata[5];
        got.ev_key = m_axis_tdata[37:6];
        got.ev_size = m_axis_tdata[77:38];
        got.count = m_axis_tdata[82:78];
        if (expected_outcomes.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transfer %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_outcomes.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display({"mismatch: expected st=%0d hit=%0d slot=%0d ev=%0d key=%h ",
                        "size=%h n=%0d, got st=%0d hit=%0d slot=%0d ev=%0d key=%h ",
                        "size=%h n=%0d"},
                want.status, want.hit, want.slot, want.evicted, want.ev_key,
                want.ev_size, want.count, got.status, got.hit, got.slot,
                got.evicted, got.ev_key, got.ev_size, got.count);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_outcomes.size();
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/lru_cache_directory_with_pinning_test.sv =====
`default_nettype none
module lru_cache_directory_with_pinning_test;
  import lrud_pkg::*;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [143:0]  s_axis_tdata = '0;
  logic [2:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [87:0]   m_axis_tdata;
  logic [2:0]    m_axis_tuser;
  logic          cfg_we = 1'b0;
  logic [31:0]   cfg_wdata = '0;
  int            fail_count;
  int            pending_count;
  bit            hold_off = 1'b0;
  logic [31:0]   key_pool [8];
  logic [31:0]   clock_now = 32'd100;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lru_cache_directory_with_pinning dut (.*);

  lru_cache_directory_with_pinning_checker monitor (.*);

  always @(posedge clk) begin
    if (rst || hold_off) m_axis_tready <= 1'b0;
    else case ($urandom_range(0, 3))
      0: m_axis_tready <= $urandom_range(0, 3) == 0;
      default: m_axis_tready <= 1'b1;
    endcase
  end

  task automatic send_event(input kind_t kind, input logic [31:0] key,
                            input logic [31:0] now, input logic ok,
                            input logic [39:0] fsize, input logic [31:0] mem);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {7'd0, mem, fsize, ok, now, key};
    do @(posedge clk); while (!s_axis_tready);
    if ($urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_floor(input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (25) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_event();
    logic [31:0] key;
    logic [39:0] fsize;
    int          pick;
    kind_t       kind;
    key = $urandom_range(0, 9) == 0 ? $urandom() : key_pool[$urandom_range(0, 7)];
    pick = $urandom_range(0, 99);
    if (pick < 22) kind = KIND_START;
    else if (pick < 42) kind = KIND_DONE;
    else if (pick < 60) kind = KIND_LOOKUP;
    else if (pick < 80) kind = KIND_PRESSURE;
    else if (pick < 86) kind = KIND_CANCEL;
    else if (pick < 91) kind = KIND_PIN;
    else if (pick < 96) kind = KIND_UNPIN;
    else kind = KIND_NONE;
    fsize = {$urandom(), 8'($urandom())};
    if ($urandom_range(0, 2) != 0) clock_now = clock_now + $urandom_range(0, 3);
    else clock_now = $urandom();
    send_event(kind, key, clock_now, $urandom_range(0, 3) != 0, fsize,
               $urandom_range(0, 5) == 0 ? 32'd0 : $urandom());
  endtask

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_event(KIND_LOOKUP, 32'hffffffff, '1, 1'b1, '1, '1);
    send_event(KIND_PRESSURE, 32'd0, 32'd0, 1'b0, '0, 32'd5);
    send_event(KIND_PIN, 32'd7, 32'd1, 1'b0, '0, '0);
    for (int i = 0; i < 17; i++)
      send_event(KIND_START, i, 32'd10 + i, 1'b0, '0, '0);
    send_event(KIND_START, 32'd3, 32'd40, 1'b0, '0, '0);
    send_event(KIND_DONE, 32'd3, 32'd41, 1'b1, '1, '0);
    send_event(KIND_DONE, 32'd7, 32'd41, 1'b1, 40'd5, '0);
    send_event(KIND_DONE, 32'd5, 32'd41, 1'b0, '0, '0);
    send_event(KIND_LOOKUP, 32'd5, 32'd42, 1'b0, '0, '0);
    send_event(KIND_START, 32'd5, 32'd43, 1'b0, '0, '0);
    send_event(KIND_CANCEL, 32'd4, 32'd44, 1'b0, '0, '0);
    send_event(KIND_LOOKUP, 32'd3, 32'hffffffff, 1'b0, '0, '0);
    send_event(KIND_PRESSURE, 32'd0, 32'd0, 1'b0, '0, 32'd1);
    send_event(KIND_PRESSURE, 32'd0, 32'd0, 1'b0, '0, 32'd1);
    send_event(KIND_PRESSURE, 32'd0, 32'd0, 1'b0, '0, 32'd1048576);
    send_event(KIND_UNPIN, 32'd99, 32'd50, 1'b0, '0, '0);
    send_event(KIND_UNPIN, 32'd99, 32'd50, 1'b0, '0, '0);
    send_event(KIND_NONE, '1, '1, 1'b1, '1, '1);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_floor(32'hffffffff);
        1: write_floor(32'd0);
        2: write_floor(32'h8000_0000);
        default: write_floor(32'hffffffff);
      endcase
      if (phase == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 210; n++) random_event();
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
